// ===== src/kwsm_pkg.sv =====
// shared constants, types and codes for the k-way sorted merge engine
package kwsm_pkg;

	localparam int NUM_LISTS  = 8;
	localparam int LIST_DEPTH = 64;

	localparam int ID_W      = 3;
	localparam int VAL_W     = 32;
	localparam int LIST_W    = $clog2(NUM_LISTS);
	localparam int LEAVES    = 1 << LIST_W;
	localparam int PTR_W     = $clog2(LIST_DEPTH);
	localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W    = LIST_W + PTR_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;

	typedef logic [LIST_W-1:0] idx_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		STS_PUSH_OK = 2'd0,
		STS_POPPED  = 2'd1,
		STS_DROPPED = 2'd2,
		STS_EMPTY   = 2'd3
	} status_code_t;

	typedef enum logic {
		CS_IDLE   = 1'b0,
		CS_REFILL = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic exec;
		logic refill;
	} dp_cmd_t;

	typedef struct packed {
		logic refill_needed;
	} dp_sts_t;

endpackage

// ===== src/k_way_sorted_merge.sv =====
// Merges up to NUM_LISTS ascending lists held in one shared list memory. A push
// item appends a signed value to one list, or is dropped if that list is full; a
// pop item returns the smallest head over all non-empty lists (lowest list wins a
// tie), or an empty status if all are empty. If the popped list still holds
// entries, a refill step follows, as the new head comes from the registered read
// of the list memory. Heads live in registers and are compared by a minimum tree.
// Every item gives one result through an output register, so the next item is
// taken while a result waits as long as that result is being taken in the same
// cycle. Fill counts track the lists, so no clearing pass follows reset.
module k_way_sorted_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [kwsm_pkg::ID_W-1:0]     list_id,
	input  logic signed [kwsm_pkg::VAL_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic signed [kwsm_pkg::VAL_W-1:0] out_value,
	output logic [kwsm_pkg::ID_W-1:0]     source_list
);

	import kwsm_pkg::*;

	dp_cmd_t      cmd;
	dp_sts_t      sts;
	status_code_t status_code;

	kwsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	kwsm_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.list_id    (list_id),
		.value      (value),
		.status     (status_code),
		.out_value  (out_value),
		.source_list(source_list)
	);

	assign status = status_code;

	a_refill_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && sts.refill_needed |=> cmd.refill)
		else $error("head refill did not follow a pop");

	a_refill_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refill |=> !cmd.refill && !in_stall || !cmd.refill)
		else $error("head refill lasted more than one cycle");

	a_no_accept_in_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refill |-> in_stall && !cmd.exec)
		else $error("item taken during head refill");

	a_result_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid)
		else $error("item gave no result");

	a_empty_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code != STS_POPPED) |-> (out_value == '0) && (source_list == '0))
		else $error("nonzero fields on a result without a popped value");

endmodule

// ===== src/kwsm_ram.sv =====
// generic simple dual-port ram with registered read
module kwsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/kwsm_datapath.sv =====
// list pointers, head registers, minimum tree, list memory and result register
module kwsm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kwsm_pkg::dp_cmd_t             cmd,
	output kwsm_pkg::dp_sts_t             sts,
	input  logic                          action,
	input  logic [kwsm_pkg::ID_W-1:0]     list_id,
	input  logic signed [kwsm_pkg::VAL_W-1:0] value,
	output kwsm_pkg::status_code_t        status,
	output logic signed [kwsm_pkg::VAL_W-1:0] out_value,
	output logic [kwsm_pkg::ID_W-1:0]     source_list
);

	import kwsm_pkg::*;

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(LIST_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	ptr_t                    rd_ptr_q [NUM_LISTS];
	ptr_t                    wr_ptr_q [NUM_LISTS];
	cnt_t                    fill_q   [NUM_LISTS];
	logic signed [VAL_W-1:0] head_q   [NUM_LISTS];
	idx_t                    refill_list_q;

	status_code_t            status_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [ID_W-1:0]         source_list_q;

	logic                    node_v   [1:2*LEAVES-1];
	logic signed [VAL_W-1:0] node_val [1:2*LEAVES-1];
	idx_t                    node_idx [1:2*LEAVES-1];

	idx_t                    push_idx;
	logic                    push_in_range;
	logic                    push_ok;
	logic                    pop_ok;
	idx_t                    best;
	ptr_t                    pop_next_ptr;
	status_code_t            status_d;

	logic                    ram_we;
	logic                    ram_re;
	addr_t                   ram_waddr;
	addr_t                   ram_raddr;
	logic [VAL_W-1:0]        ram_rdata;

	// leaves of the minimum tree
	for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
		if (k < NUM_LISTS) begin : g_used
			assign node_v[LEAVES+k]   = (fill_q[k] != '0);
			assign node_val[LEAVES+k] = head_q[k];
		end else begin : g_pad
			assign node_v[LEAVES+k]   = 1'b0;
			assign node_val[LEAVES+k] = '0;
		end
		assign node_idx[LEAVES+k] = idx_t'(k);
	end

	// inner nodes, lower list wins a tie
	for (genvar i = 1; i < LEAVES; i++) begin : g_node
		logic pick_r;
		assign pick_r = node_v[2*i+1] &&
			(!node_v[2*i] || (node_val[2*i+1] < node_val[2*i]));
		assign node_v[i]   = node_v[2*i] || node_v[2*i+1];
		assign node_val[i] = pick_r ? node_val[2*i+1] : node_val[2*i];
		assign node_idx[i] = pick_r ? node_idx[2*i+1] : node_idx[2*i];
	end

	assign best          = node_idx[1];
	assign pop_ok        = action && node_v[1];
	assign pop_next_ptr  = ptr_inc(rd_ptr_q[best]);

	assign push_idx      = idx_t'(list_id);
	assign push_in_range = (32'(list_id) < NUM_LISTS);
	assign push_ok       = !action && push_in_range &&
		(fill_q[push_idx] != cnt_t'(LIST_DEPTH));

	assign sts.refill_needed = pop_ok && (fill_q[best] != cnt_t'(1));

	always_comb begin
		if (action) begin
			status_d = node_v[1] ? STS_POPPED : STS_EMPTY;
		end else begin
			status_d = push_ok ? STS_PUSH_OK : STS_DROPPED;
		end
	end

	assign ram_we    = cmd.exec && push_ok;
	assign ram_waddr = {push_idx, wr_ptr_q[push_idx]};
	assign ram_re    = cmd.exec && pop_ok;
	assign ram_raddr = {best, pop_next_ptr};

	kwsm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(RAM_DEPTH)
	) u_list_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LISTS; k++) begin
				rd_ptr_q[k] <= '0;
				wr_ptr_q[k] <= '0;
				fill_q[k]   <= '0;
			end
		end else if (cmd.exec) begin
			if (push_ok) begin
				wr_ptr_q[push_idx] <= ptr_inc(wr_ptr_q[push_idx]);
				fill_q[push_idx]   <= cnt_t'(fill_q[push_idx] + 1'b1);
			end
			if (pop_ok) begin
				rd_ptr_q[best] <= pop_next_ptr;
				fill_q[best]   <= cnt_t'(fill_q[best] - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			// an empty list takes its first value straight into the head
			if (push_ok && (fill_q[push_idx] == '0)) begin
				head_q[push_idx] <= value;
			end
			refill_list_q <= best;
			status_q      <= status_d;
			out_value_q   <= pop_ok ? node_val[1] : '0;
			source_list_q <= pop_ok ? ID_W'(best) : '0;
		end
		if (cmd.refill) begin
			head_q[refill_list_q] <= ram_rdata;
		end
	end

	assign status      = status_q;
	assign out_value   = out_value_q;
	assign source_list = source_list_q;

endmodule

// ===== src/kwsm_ctrl.sv =====
// controller: item sequencing, head refill step and result valid
module kwsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output kwsm_pkg::dp_cmd_t cmd,
	input  kwsm_pkg::dp_sts_t sts
);

	import kwsm_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (cmd.exec && sts.refill_needed) begin
					state_d = CS_REFILL;
				end
			end
			CS_REFILL: begin
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			CS_IDLE: begin
				in_stall = !out_free;
				cmd.exec = in_valid && out_free;
			end
			CS_REFILL: begin
				cmd.refill = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== dv/tb_k_way_sorted_merge.sv =====
// self-checking testbench for the k-way sorted merge engine with a merge predictor scoreboard
module tb_k_way_sorted_merge;
	import kwsm_pkg::*;

	localparam logic ACT_PUSH     = 1'b0;
	localparam logic ACT_POP      = 1'b1;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   STALL_LIMIT  = 2000;
	localparam int   PHASE_ITEMS  = 285;
	localparam int   SETTLE_TICKS = 10;

	typedef struct {
		status_code_t             st;
		logic signed [VAL_W-1:0]  val;
		logic [ID_W-1:0]          src;
	} merge_result_t;

	class merge_scoreboard;
		logic signed [VAL_W-1:0] lists [NUM_LISTS][LIST_DEPTH];
		int rd_at [NUM_LISTS];
		int wr_at [NUM_LISTS];
		int fill  [NUM_LISTS];
		merge_result_t awaited [$];
		int errors;
		int kept, dropped, popped, empties, wraps, ties, checked;

		function int pending();
			return awaited.size();
		endfunction

		function int bump(int p);
			if (p + 1 >= LIST_DEPTH) begin
				wraps++;
				return 0;
			end
			return p + 1;
		endfunction

		function merge_result_t merge_step(logic act, logic [ID_W-1:0] id,
				logic signed [VAL_W-1:0] v);
			merge_result_t r;
			bit found;
			int best;
			logic signed [VAL_W-1:0] best_val;
			logic signed [VAL_W-1:0] h;
			r.st = STS_PUSH_OK;
			r.val = '0;
			r.src = '0;
			found = 0;
			best = 0;
			best_val = '0;
			if (act == ACT_PUSH) begin
				if (int'(id) >= NUM_LISTS || fill[id] >= LIST_DEPTH) begin
					r.st = STS_DROPPED;
					dropped++;
					return r;
				end
				lists[id][wr_at[id]] = v;
				wr_at[id] = bump(wr_at[id]);
				fill[id]++;
				kept++;
				return r;
			end
			for (int k = 0; k < NUM_LISTS; k++) begin
				if (fill[k] != 0) begin
					h = lists[k][rd_at[k]];
					if (found && h == best_val)
						ties++;
					if (!found || h < best_val) begin
						found = 1;
						best = k;
						best_val = h;
					end
				end
			end
			if (!found) begin
				r.st = STS_EMPTY;
				empties++;
				return r;
			end
			rd_at[best] = bump(rd_at[best]);
			fill[best]--;
			popped++;
			r.st = STS_POPPED;
			r.val = best_val;
			r.src = ID_W'(best);
			return r;
		endfunction

		function void take_item(logic act, logic [ID_W-1:0] id, logic signed [VAL_W-1:0] v);
			awaited.insert(awaited.size(), merge_step(act, id, v));
		endfunction

		function void match_result(logic [1:0] st, logic signed [VAL_W-1:0] v,
				logic [ID_W-1:0] src);
			merge_result_t e;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: status %0d value %0d source %0d",
					st, v, src);
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				errors++;
			end
			if (v !== e.val) begin
				$error("out_value: expected %0d, got %0d", e.val, v);
				errors++;
			end
			if (src !== e.src) begin
				$error("source_list: expected %0d, got %0d", e.src, src);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    action = ACT_PUSH;
	logic [ID_W-1:0]         list_id = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              status;
	logic signed [VAL_W-1:0] out_value;
	logic [ID_W-1:0]         source_list;

	merge_scoreboard sb;
	int  send_pct = 0;
	int  recv_pct = 0;
	int  sent_items = 0;
	bit  hold_req = 0;
	int  hold_done = 0;
	int  input_held = 0;
	logic signed [VAL_W-1:0] tail [NUM_LISTS];
	bit  tail_set [NUM_LISTS];

	k_way_sorted_merge u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.list_id    (list_id),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_value  (out_value),
		.source_list(source_list)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: check, then pick next stall
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0)
				sb.match_result(status, out_value, source_list);
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
				hold_done++;
			end else begin
				out_stall <= ($urandom_range(99) < recv_pct);
			end
		end
	end

	// watchdog on handshake activity
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (in_valid && in_stall === 1'b1)
				input_held++;
			if (arst_n && !((in_valid && in_stall === 1'b0) ||
					(out_valid === 1'b1 && !out_stall)))
				quiet++;
			else
				quiet = 0;
			if (quiet >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results outstanding",
					quiet, sb.pending());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_item(input logic act, input logic [ID_W-1:0] id,
			input logic signed [VAL_W-1:0] v);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		list_id <= id;
		value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.take_item(act, id, v);
		sent_items++;
	endtask

	task automatic send_pop();
		send_item(ACT_POP, ID_W'($urandom_range(NUM_LISTS - 1)), int'($urandom));
	endtask

	task automatic push_sorted(input int id);
		longint nxt;
		if (!tail_set[id] || $urandom_range(39) == 0) begin
			if ($urandom_range(3) == 0)
				nxt = longint'(int'($urandom));
			else
				nxt = longint'($urandom_range(2000)) - 1000;
		end else begin
			nxt = longint'(tail[id]) + $urandom_range(0, 1 << $urandom_range(0, 6));
		end
		if (nxt > longint'(32'sh7fffffff))
			nxt = longint'($urandom_range(2000)) - 1000;
		tail[id] = VAL_W'(nxt);
		tail_set[id] = 1;
		send_item(ACT_PUSH, ID_W'(id), tail[id]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic run_random(input int n_items);
		int start, kind, id, len;
		start = sent_items;
		while (sent_items - start < n_items) begin
			kind = $urandom_range(99);
			id = $urandom_range(NUM_LISTS - 1);
			if (kind < 45) begin
				len = $urandom_range(1, 24);
				repeat (len) push_sorted(id);
			end else if (kind < 53) begin
				// fill one list past its depth
				len = LIST_DEPTH - sb.fill[id] + $urandom_range(1, 3);
				repeat (len) push_sorted(id);
			end else if (kind < 85) begin
				len = $urandom_range(1, 40);
				repeat (len) send_pop();
			end else begin
				len = $urandom_range(1, 10);
				repeat (len)
					send_item(logic'($urandom_range(1)),
						ID_W'($urandom_range(NUM_LISTS - 1)), int'($urandom));
			end
		end
	endtask

	initial begin
		sb = new;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ties, empty pops, unsorted list
		send_item(ACT_POP, 3'd7, 32'shffffffff);
		send_item(ACT_PUSH, 3'd0, 32'sh80000000);
		send_item(ACT_PUSH, 3'd7, 32'sh7fffffff);
		send_item(ACT_PUSH, 3'd3, -32'sd1);
		send_item(ACT_PUSH, 3'd5, 32'sd0);
		send_item(ACT_PUSH, 3'd6, 32'sd5);
		send_item(ACT_PUSH, 3'd2, 32'sd5);
		send_item(ACT_PUSH, 3'd4, 32'sd5);
		repeat (7) send_pop();
		send_item(ACT_POP, 3'd0, 32'sh0);
		send_item(ACT_PUSH, 3'd1, 32'sd10);
		send_item(ACT_PUSH, 3'd1, 32'sd3);
		send_pop();
		send_pop();
		wait_drained();

		// no idling, with one long result hold-off
		hold_req = 1;
		run_random(PHASE_ITEMS);
		wait_drained();

		send_pct = 77;
		recv_pct = 0;
		run_random(PHASE_ITEMS);
		wait_drained();

		send_pct = 0;
		recv_pct = 77;
		run_random(PHASE_ITEMS);
		wait_drained();

		send_pct = 24;
		recv_pct = 24;
		run_random(PHASE_ITEMS);
		wait_drained();

		recv_pct = 0;
		repeat (SETTLE_TICKS) @(posedge clk);

		$display("merge run: %0d items, %0d results checked; %0d pushes kept, %0d dropped full",
			sent_items, sb.checked, sb.kept, sb.dropped);
		$display("  %0d pops, %0d on empty, %0d ties, %0d wraps, %0d stall, %0d hold cycles",
			sb.popped, sb.empties, sb.ties, sb.wraps, input_held, hold_done);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
